@@ hdl/swbl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swbl_pkg
// Shared types and constants of the sliding window burst limiter.
// ---------------------------------------------------------------------------
package swbl_pkg;

    localparam int TIME_W    = 32;
    localparam int BITS_W    = 32;
    localparam int PAYLOAD_W = 16;
    localparam int PBITS_W   = 20;  // max(65535 + 66, 84) * 8 fits in 20 bits
    localparam int COUNT_W   = 6;   // entry_count field width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [PAYLOAD_W:0] OVERHEAD_BYTES  = 17'd66;
    localparam logic [PAYLOAD_W:0] MIN_FRAME_BYTES = 17'd84;

    localparam logic REQ_QUERY  = 1'b0;
    localparam logic REQ_RECORD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLIMITED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US  = 2'd2;

    localparam logic [BITS_W-1:0] WINDOW_RESET = 32'd200000;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        logic shift;  // take neighbor's entry (head pop)
        logic load;   // write new entry
        logic merge;  // add bits into entry, refresh time
    } t_cell_ctl;

    function automatic logic [PBITS_W-1:0] wire_bits(input logic [PAYLOAD_W-1:0] payload);
        logic [PAYLOAD_W:0] bytes;
        bytes = {1'b0, payload} + OVERHEAD_BYTES;
        if (bytes < MIN_FRAME_BYTES) begin
            bytes = MIN_FRAME_BYTES;
        end
        return {bytes, 3'b000};
    endfunction

endpackage

@@ hdl/swbl_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swbl_req_if
// Request channel: valid/ready with one request word.
// ---------------------------------------------------------------------------
interface swbl_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [swbl_pkg::TIME_W-1:0]    now_us;
    logic [swbl_pkg::PAYLOAD_W-1:0] payload_len;

    modport source (output valid, req_type, now_us, payload_len, input ready);
    modport sink   (input valid, req_type, now_us, payload_len, output ready);
endinterface

@@ hdl/swbl_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swbl_rsp_if
// Response channel: valid/ready with one result word.
// ---------------------------------------------------------------------------
interface swbl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       allowed;
    logic [swbl_pkg::BITS_W-1:0]  window_bits;
    logic [swbl_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, allowed, window_bits, entry_count, input ready);
    modport sink   (input valid, allowed, window_bits, entry_count, output ready);
endinterface

@@ hdl/swbl_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swbl_cell
// One history slot: time stamp and wire bits, shifts toward the head.
// ---------------------------------------------------------------------------
module swbl_cell (
    input  logic                          i_clk,
    input  swbl_pkg::t_cell_ctl           i_ctl,
    input  logic [swbl_pkg::TIME_W-1:0]   i_next_time,
    input  logic [swbl_pkg::BITS_W-1:0]   i_next_bits,
    input  logic [swbl_pkg::TIME_W-1:0]   i_now,
    input  logic [swbl_pkg::PBITS_W-1:0]  i_pbits,
    output logic [swbl_pkg::TIME_W-1:0]   o_time,
    output logic [swbl_pkg::BITS_W-1:0]   o_bits
);
    import swbl_pkg::*;

    logic [TIME_W-1:0] r_time, n_time;
    logic [BITS_W-1:0] r_bits, n_bits;

    always_comb begin
        n_time = r_time;
        n_bits = r_bits;
        if (i_ctl.shift) begin
            n_time = i_next_time;
            n_bits = i_next_bits;
        end else if (i_ctl.load) begin
            n_time = i_now;
            n_bits = {{(BITS_W-PBITS_W){1'b0}}, i_pbits};
        end else if (i_ctl.merge) begin
            n_time = i_now;
            n_bits = r_bits + {{(BITS_W-PBITS_W){1'b0}}, i_pbits};
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_bits <= n_bits;
    end

    assign o_time = r_time;
    assign o_bits = r_bits;

endmodule

@@ hdl/sliding_window_burst_limiter_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_burst_limiter_core
// Sliding window bit budget over a shifting row of history cells.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  i_req    in   valid/ready        req_type, now_us, payload_len
//  o_rsp    out  valid/ready        allowed, window_bits, entry_count
//  i_cfg_*  in   write enable only  i_cfg_idx, i_cfg_data
//
//  A request is accepted, then the head cell pops one expired entry per cycle,
//  then the answer cycle follows. The response register holds the result until
//  taken; a full register delays the answer cycle. Synchronous active-low reset
//  clears count and sum and sets config to unlimited, limit 0, WINDOW_RESET window.
//  Writes to the three config registers clear the history; cell contents are not cleared.
// ---------------------------------------------------------------------------
module sliding_window_burst_limiter_core #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swbl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    swbl_req_if.sink                        i_req,
    swbl_rsp_if.source                      o_rsp
);
    import swbl_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                r_state, n_state;
    logic                r_unlim;
    logic [BITS_W-1:0]   r_limit;
    logic [TIME_W-1:0]   r_window;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [BITS_W-1:0]   r_sum, n_sum;

    logic                r_req;
    logic [TIME_W-1:0]   r_now;
    logic [PBITS_W-1:0]  r_pbits;

    logic                r_out_valid, n_out_valid;
    logic                r_out_allowed, n_out_allowed;
    logic [BITS_W-1:0]   r_out_bits, n_out_bits;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [TIME_W-1:0]   w_time [HISTORY_DEPTH];
    logic [BITS_W-1:0]   w_bits [HISTORY_DEPTH];
    t_cell_ctl           w_ctl  [HISTORY_DEPTH];

    logic                w_accept;
    logic                w_head_exp;
    logic                w_finish;
    logic                w_append;
    logic                w_merge;
    logic [BITS_W-1:0]   w_pbits32;
    logic [TIME_W-1:0]   w_age;
    logic                w_allowed;
    logic [IDX_W-1:0]    w_tail_idx;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pbits32   = {{(BITS_W-PBITS_W){1'b0}}, r_pbits};
    assign w_age       = r_now - w_time[0];
    assign w_head_exp  = (r_state == ST_RUN) && !r_unlim && (r_count != '0)
                         && (w_age >= r_window);
    assign w_finish    = (r_state == ST_RUN) && !w_head_exp
                         && (!r_out_valid || o_rsp.ready);
    assign w_append    = w_finish && (r_req == REQ_RECORD) && !r_unlim
                         && (r_count < DEPTH_CNT);
    assign w_merge     = w_finish && (r_req == REQ_RECORD) && !r_unlim
                         && (r_count == DEPTH_CNT);
    assign w_tail_idx  = r_count[IDX_W-1:0];

    always_comb begin
        if (r_unlim) begin
            w_allowed = 1'b1;
        end else if (w_pbits32 > r_limit) begin
            w_allowed = (r_count == '0);
        end else begin
            w_allowed = (r_sum <= r_limit - w_pbits32);
        end
    end

    // row of cells, index 0 is the oldest entry
    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        logic [TIME_W-1:0] w_nt;
        logic [BITS_W-1:0] w_nb;
        if (g == HISTORY_DEPTH - 1) begin : g_last
            assign w_nt = w_time[g];
            assign w_nb = w_bits[g];
        end else begin : g_mid
            assign w_nt = w_time[g+1];
            assign w_nb = w_bits[g+1];
        end
        assign w_ctl[g].shift = w_head_exp;
        assign w_ctl[g].load  = w_append && (w_tail_idx == IDX_W'(g));
        assign w_ctl[g].merge = w_merge && (g == HISTORY_DEPTH - 1);

        swbl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_next_time (w_nt),
            .i_next_bits (w_nb),
            .i_now       (r_now),
            .i_pbits     (r_pbits),
            .o_time      (w_time[g]),
            .o_bits      (w_bits[g])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_sum         = r_sum;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_allowed = r_out_allowed;
        n_out_bits    = r_out_bits;
        n_out_count   = r_out_count;
        w_count_ext   = '0;

        if (w_accept) begin
            n_state = ST_RUN;
        end
        if (w_head_exp) begin
            n_sum   = r_sum - w_bits[0];
            n_count = r_count - CNT_W'(1);
        end else if (w_finish) begin
            if (r_req == REQ_RECORD && !r_unlim) begin
                n_sum = r_sum + w_pbits32;
                if (w_append) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            w_count_ext   = {{COUNT_W{1'b0}}, n_count};
            n_state       = ST_IDLE;
            n_out_valid   = 1'b1;
            n_out_allowed = (r_req == REQ_QUERY) && w_allowed;
            n_out_bits    = n_sum;
            n_out_count   = w_count_ext[COUNT_W-1:0];
        end
        // a config register write clears history; the user writes only while idle, the block does not enforce it
        if (i_cfg_we && (i_cfg_idx == CFG_UNLIMITED || i_cfg_idx == CFG_LIMIT_BITS
                         || i_cfg_idx == CFG_WINDOW_US)) begin
            n_count = '0;
            n_sum   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_unlim     <= 1'b1;
            r_limit     <= '0;
            r_window    <= WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UNLIMITED:  r_unlim  <= i_cfg_data[0];
                    CFG_LIMIT_BITS: r_limit  <= i_cfg_data;
                    CFG_WINDOW_US:  r_window <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req.req_type;
            r_now   <= i_req.now_us;
            r_pbits <= wire_bits(i_req.payload_len);
        end
        r_out_allowed <= n_out_allowed;
        r_out_bits    <= n_out_bits;
        r_out_count   <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.allowed     = r_out_allowed;
    assign o_rsp.window_bits = r_out_bits;
    assign o_rsp.entry_count = r_out_count;

endmodule

@@ hdl/swbl_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swbl_checker
// Port-level checks of the burst limiter, bound to the top level.
// ---------------------------------------------------------------------------
module swbl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic                           i_rsp_allowed,
    input logic [swbl_pkg::BITS_W-1:0]    i_rsp_bits,
    input logic [swbl_pkg::COUNT_W-1:0]   i_rsp_count
);
    import swbl_pkg::*;

    // result word holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_allowed)
            && $stable(i_rsp_bits) && $stable(i_rsp_count))
        else $error("response word changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // one word in flight: no new request until this one is answered
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // valid may not rise straight after the accept; the request is worked on first
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_rsp_valid))
        else $error("response too early");

endmodule

bind sliding_window_burst_limiter_core swbl_checker u_swbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_allowed (o_rsp.allowed),
    .i_rsp_bits    (o_rsp.window_bits),
    .i_rsp_count   (o_rsp.entry_count)
);

@@ sim/sliding_window_burst_limiter_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_burst_limiter_core_test
// Self-checking bench for the sliding window burst limiter core.
// Requests are queued by the stimulus block and fed to the core by a clocked
// driver. A bit-accurate copy of the ring, sum and registers predicts each
// answer at acceptance. A clocked monitor checks every returned word in order.
// Covered: boundary cases, register extremes, full ring merging, and random
// bursts under several idle/stall mixes, including one long output hold-off.
// ---------------------------------------------------------------------------
module sliding_window_burst_limiter_core_test;
    import swbl_pkg::*;

    localparam int RING_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_GAP  = 40;       // outlasts a request that expires the whole ring

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // not a register

    typedef struct packed {
        logic                 req_type;
        logic [TIME_W-1:0]    now_us;
        logic [PAYLOAD_W-1:0] payload_len;
    } t_limiter_req;

    typedef struct packed {
        logic               allowed;
        logic [BITS_W-1:0]  window_bits;
        logic [COUNT_W-1:0] entry_count;
    } t_limiter_rsp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    swbl_req_if req_ch ();
    swbl_rsp_if rsp_ch ();

    sliding_window_burst_limiter_core #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // shadow of the limiter state
    logic [TIME_W-1:0] hist_time [RING_DEPTH];
    logic [BITS_W-1:0] hist_bits [RING_DEPTH];
    int                hist_head;
    int                hist_count;
    logic [BITS_W-1:0] hist_sum;
    logic              cfg_unlimited;
    logic [BITS_W-1:0] cfg_limit;
    logic [BITS_W-1:0] cfg_window;

    t_limiter_req request_q [$];
    t_limiter_rsp answer_q [$];
    t_limiter_req drv_word;
    t_limiter_rsp mon_want;

    int                issued_cnt;
    int                checked_cnt;
    int                fail_cnt;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_requests;
    int                holds_taken;
    int                hold_left;
    int                cycle_cnt;
    logic [TIME_W-1:0] stim_now;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [BITS_W-1:0] frame_bits(input logic [PAYLOAD_W-1:0] payload);
        logic [BITS_W-1:0] bytes;
        bytes = BITS_W'(payload) + BITS_W'(OVERHEAD_BYTES);
        if (bytes < BITS_W'(MIN_FRAME_BYTES)) begin
            bytes = BITS_W'(MIN_FRAME_BYTES);
        end
        return bytes << 3;
    endfunction

    // drop head entries whose age (mod 2^32) reached the window
    function automatic void age_out(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        while (hist_count != 0) begin
            age = now - hist_time[hist_head];
            if (age < cfg_window) begin
                break;
            end
            hist_sum   = hist_sum - hist_bits[hist_head];
            hist_head  = (hist_head + 1) % RING_DEPTH;
            hist_count = hist_count - 1;
        end
    endfunction

    function automatic t_limiter_rsp limiter_step(input t_limiter_req w);
        t_limiter_rsp      r;
        logic [BITS_W-1:0] pbits;
        int                slot;
        pbits     = frame_bits(w.payload_len);
        r.allowed = 1'b0;
        if (w.req_type == REQ_QUERY) begin
            if (cfg_unlimited) begin
                r.allowed = 1'b1;
            end else begin
                age_out(w.now_us);
                if (pbits > cfg_limit) begin
                    r.allowed = (hist_count == 0);
                end else begin
                    r.allowed = (hist_sum <= cfg_limit - pbits);
                end
            end
        end else if (!cfg_unlimited) begin
            age_out(w.now_us);
            if (hist_count < RING_DEPTH) begin
                slot            = (hist_head + hist_count) % RING_DEPTH;
                hist_bits[slot] = pbits;
                hist_count      = hist_count + 1;
            end else begin
                // ring full: fold into the newest entry
                slot            = (hist_head + hist_count - 1) % RING_DEPTH;
                hist_bits[slot] = hist_bits[slot] + pbits;
            end
            hist_time[slot] = w.now_us;
            hist_sum        = hist_sum + pbits;
        end
        r.window_bits = hist_sum;
        r.entry_count = COUNT_W'(hist_count);
        return r;
    endfunction

    task automatic add_req(input logic kind, input logic [TIME_W-1:0] now,
                           input logic [PAYLOAD_W-1:0] pay);
        request_q.push_back('{kind, now, pay});
        issued_cnt++;
    endtask

    // called on a falling edge with nothing outstanding
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_UNLIMITED:  cfg_unlimited = data[0];
            CFG_LIMIT_BITS: cfg_limit     = data;
            CFG_WINDOW_US:  cfg_window    = data;
            default: ;
        endcase
        if (idx != CFG_SPARE_IDX) begin
            hist_head  = 0;
            hist_count = 0;
            hist_sum   = '0;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        while (checked_cnt != issued_cnt) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // bursts of closely spaced requests separated by gaps relative to the window
    task automatic gen_traffic(input int n);
        int                   left;
        int                   burst;
        int                   k;
        logic [TIME_W-1:0]    span;
        logic [PAYLOAD_W-1:0] pay;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(48, 4);
            if (burst > left) begin
                burst = left;
            end
            case ($urandom_range(3))
                0:       span = '0;
                1:       span = cfg_window / 256 + 1;
                2:       span = cfg_window / 32 + 1;
                default: span = cfg_window / 4 + 1;
            endcase
            for (k = 0; k < burst; k++) begin
                if ($urandom_range(99) < 4) begin
                    stim_now = $urandom;
                end else begin
                    stim_now = stim_now + $urandom_range(span);
                end
                case ($urandom_range(9))
                    0:       pay = $urandom_range(22, 14);  // around the minimum frame
                    1:       pay = '1;
                    2:       pay = $urandom;
                    default: pay = $urandom_range(1500);
                endcase
                add_req($urandom_range(1) ? REQ_RECORD : REQ_QUERY, stim_now, pay);
            end
            left = left - burst;
            case ($urandom_range(2))
                0:       ;
                1:       stim_now = stim_now + cfg_window / 2;
                default: stim_now = stim_now + cfg_window + $urandom_range(cfg_window / 2 + 1);
            endcase
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                answer_q.push_back(limiter_step(drv_word));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_word            = request_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= drv_word.req_type;
                    req_ch.now_us      <= drv_word.now_us;
                    req_ch.payload_len <= drv_word.payload_len;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, armed by the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left   <= 0;
            holds_taken <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_taken != hold_requests) begin
            hold_left   <= HOLD_CYCLES;
            holds_taken <= hold_requests;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (answer_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_cnt++;
                end else begin
                    mon_want = answer_q.pop_front();
                    checked_cnt++;
                    if (rsp_ch.allowed !== mon_want.allowed) begin
                        $error("allowed: expected %0d, got %0d",
                               mon_want.allowed, rsp_ch.allowed);
                        fail_cnt++;
                    end
                    if (rsp_ch.window_bits !== mon_want.window_bits) begin
                        $error("window_bits: expected %0d, got %0d",
                               mon_want.window_bits, rsp_ch.window_bits);
                        fail_cnt++;
                    end
                    if (rsp_ch.entry_count !== mon_want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               mon_want.entry_count, rsp_ch.entry_count);
                        fail_cnt++;
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                ph;
        int                k;
        logic              unl;
        logic [BITS_W-1:0] lim;
        logic [BITS_W-1:0] win;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_QUERY;
        req_ch.now_us        = '0;
        req_ch.payload_len   = '0;
        rsp_ch.ready         = 1'b0;
        issued_cnt           = 0;
        checked_cnt          = 0;
        fail_cnt             = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_requests        = 0;
        hist_head            = 0;
        hist_count           = 0;
        hist_sum             = '0;
        cfg_unlimited        = 1'b1;
        cfg_limit            = '0;
        cfg_window           = WINDOW_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: unlimited, records ignored
        add_req(REQ_QUERY, 32'hFFFF_FFFF, '1);
        add_req(REQ_RECORD, '0, '0);
        settle();

        // budget of three minimum frames, 1000 us window
        write_reg(CFG_UNLIMITED, '0);
        write_reg(CFG_LIMIT_BITS, 32'd2016);
        write_reg(CFG_WINDOW_US, 32'd1000);
        add_req(REQ_RECORD, 32'd100, 16'd17);
        add_req(REQ_RECORD, 32'd200, 16'd18);
        add_req(REQ_QUERY, 32'd300, 16'd0);          // sum equals limit - frame
        add_req(REQ_RECORD, 32'd300, 16'd19);
        add_req(REQ_QUERY, 32'd300, 16'd0);
        add_req(REQ_QUERY, 32'd300, 16'hFFFF);       // oversized, ring not empty
        add_req(REQ_QUERY, 32'd1100, 16'd0);         // age exactly one window
        add_req(REQ_QUERY, 32'd5000, 16'hFFFF);      // oversized, ring empty
        add_req(REQ_RECORD, 32'hFFFF_FE00, 16'd0);
        add_req(REQ_QUERY, 32'h0000_0100, 16'd1500); // time wrapped, entry kept
        add_req(REQ_QUERY, 32'h0000_01E8, 16'd0);    // wrapped age hits the window
        add_req(REQ_RECORD, 32'h0000_0200, 16'd0);
        settle();
        write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);     // history must survive
        add_req(REQ_QUERY, 32'h0000_0200, 16'd0);
        settle();
        write_reg(CFG_WINDOW_US, '0);                // everything expires at once
        add_req(REQ_RECORD, 32'h0000_0300, 16'd100);
        add_req(REQ_QUERY, 32'h0000_0300, 16'd0);
        settle();
        write_reg(CFG_UNLIMITED, 32'd1);
        add_req(REQ_RECORD, 32'd7, 16'd500);
        add_req(REQ_QUERY, 32'd7, 16'hFFFF);
        settle();
        write_reg(CFG_LIMIT_BITS, '0);
        write_reg(CFG_UNLIMITED, '0);
        write_reg(CFG_WINDOW_US, 32'd1000);
        add_req(REQ_QUERY, 32'd8, 16'd0);
        add_req(REQ_RECORD, 32'd8, 16'd0);
        add_req(REQ_QUERY, 32'd8, 16'd0);
        settle();

        // full ring, further records merge into the newest entry
        write_reg(CFG_LIMIT_BITS, 32'hFFFF_FFFF);
        write_reg(CFG_WINDOW_US, 32'hFFFF_FFFF);
        stim_now = $urandom;
        for (k = 0; k < 100; k++) begin
            add_req(REQ_RECORD, stim_now, 16'hFFFF);
            if (k % 50 == 49) begin
                add_req(REQ_QUERY, stim_now, 16'd0);
            end
        end
        add_req(REQ_QUERY, stim_now - 1, 16'd0);     // age 2^32-1 drains the ring
        settle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    unl = 1'b1;
                    lim = $urandom;
                    win = $urandom_range(5000, 100);
                end
                1: begin
                    unl = 1'b0;
                    lim = $urandom_range(40000, 4000);
                    win = $urandom_range(5000, 200);
                end
                2: begin
                    unl = 1'b0;
                    lim = '0;
                    win = 32'd1;
                end
                3: begin
                    unl = 1'b0;
                    lim = $urandom_range(40000, 2000);
                    win = '0;
                end
                4: begin
                    unl = 1'b0;
                    lim = '1;
                    win = '1;
                end
                5: begin
                    unl = 1'b0;
                    lim = $urandom_range(600000, 500000);
                    win = $urandom_range(100000, 1000);
                end
                6: begin
                    unl = 1'b0;
                    lim = $urandom;
                    win = $urandom;
                end
                default: begin
                    unl = 1'b0;
                    lim = $urandom_range(20000, 1000);
                    win = $urandom_range(3000, 50);
                end
            endcase
            write_reg(CFG_SPARE_IDX, $urandom);
            write_reg(CFG_LIMIT_BITS, lim);
            write_reg(CFG_WINDOW_US, win);
            write_reg(CFG_UNLIMITED, {31'd0, unl});
            send_idle_pct  = (ph % 4 == 1) ? 52 : ((ph % 4 == 3) ? 13 : 0);
            recv_stall_pct = (ph % 4 == 2) ? 52 : ((ph % 4 == 3) ? 13 : 0);
            if (ph == 4) begin
                hold_requests++;   // back-pressure until the core stalls its input
            end
            stim_now = $urandom;
            gen_traffic(115);
            settle();
        end

        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/swbl_pkg.sv
hdl/swbl_req_if.sv
hdl/swbl_rsp_if.sv
hdl/swbl_cell.sv
hdl/sliding_window_burst_limiter_core.sv
hdl/swbl_checker.sv
sim/sliding_window_burst_limiter_core_test.sv
